[rtl/apf_pkg.sv]
// Shared constants and types for the articulation point finder.
package apf_pkg;
   localparam int MaxVertices = 64;
   localparam int VW = $clog2(MaxVertices);
   localparam int CW = VW + 1;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_RUN   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   typedef logic [VW-1:0] vidx_type;
   typedef logic [CW-1:0] cnt_type;

   typedef struct packed {
      vidx_type vertex;
      cnt_type  pos;
      cnt_type  par;
      cnt_type  low;
      cnt_type  disc;
   } stack_entry_type;
endpackage

[rtl/apf_scan.sv]
// Priority scan: lowest set bit at or above a start position.
module apf_scan (
   input  logic [apf_pkg::MaxVertices-1:0] vec,
   input  apf_pkg::cnt_type                start,
   output logic                            found,
   output apf_pkg::vidx_type               pos
);
   logic [apf_pkg::MaxVertices-1:0] masked;
   always_comb begin
      masked = '0;
      for (int i = 0; i < apf_pkg::MaxVertices; i++) begin
         masked[i] = vec[i] && (apf_pkg::CW'(i) >= start);
      end
      found = |masked;
      pos = '0;
      for (int i = apf_pkg::MaxVertices - 1; i >= 0; i--) begin
         if (masked[i]) begin
            pos = apf_pkg::VW'(i);
         end
      end
   end
endmodule

[rtl/articulation_point_finder.sv]
// Top level: graph store, DFS sequencer and result emitter.
//  channel | dir | tvalid/tready word
//  req_    | in  | tdata = func[1:0], end_a[8:2], end_b[15:9]
//  rsp_    | out | tdata = vertex[6:0], ap_count[13:7]; tuser = none_found; tlast = last
//  csr_    | in  | write enable, vertex_count
// Add edge: accept, update row a, update row b; clear and ignored words are done at accept.
// Run: accept, then per root a pick and a row load; per neighbor scanned a step and an evaluate,
// plus a row load per push; pops restore the parent and reload its row; one shared scan unit.
// Then a count step per cut vertex plus a final one, and one result word per rsp_tready handshake.
// Reset is synchronous; the matrix reads as empty after reset or clear (row valid bits).
// req_tready stays low from accept until the word is done.
module articulation_point_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // func[1:0], end_a[8:2], end_b[15:9]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // vertex[6:0], ap_count[13:7]
   output logic        rsp_tuser,  // none_found
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata   // vertex_count
);
   localparam int N = apf_pkg::MaxVertices;
   localparam int VW = apf_pkg::VW;
   localparam int CW = apf_pkg::CW;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ADDA = 4'd1;
   localparam logic [3:0] S_ADDB = 4'd2;
   localparam logic [3:0] S_ROOT = 4'd3;
   localparam logic [3:0] S_LOAD = 4'd4;
   localparam logic [3:0] S_STEP = 4'd5;
   localparam logic [3:0] S_EVAL = 4'd6;
   localparam logic [3:0] S_POP  = 4'd7;
   localparam logic [3:0] S_POP2 = 4'd8;
   localparam logic [3:0] S_CNT  = 4'd9;
   localparam logic [3:0] S_EMIT = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [N-1:0] adj_mem [N];
   logic [N-1:0] rowok_ff;
   logic [N-1:0] row_rd_ff;
   logic rowok_rd_ff;
   logic [CW-1:0] disc_mem [N];
   logic [CW-1:0] disc_rd_ff;
   apf_pkg::stack_entry_type stack_mem [N];
   apf_pkg::stack_entry_type stk_rd_ff;
   logic [N-1:0] vis_ff, cut_ff;
   logic [6:0] vcount_ff;
   logic [N-1:0] urow_ff;
   apf_pkg::vidx_type u_ff, w_ff, ea_ff, eb_ff;
   logic [CW-1:0] upos_ff, upar_ff, ulow_ff, udisc_ff;
   logic [CW-1:0] depth_ff, time_ff, rootch_ff, idx_ff, total_ff, emitted_ff;

   logic [1:0] func;
   logic [6:0] ea, eb;
   logic edge_ok;
   assign func = req_tdata[1:0];
   assign ea = req_tdata[8:2];
   assign eb = req_tdata[15:9];
   assign edge_ok = ea >= 7'd1 && ea <= 7'(N) && eb >= 7'd1 && eb <= 7'(N) && ea != eb;

   logic [CW-1:0] n;
   logic [N-1:0] active;
   assign n = (vcount_ff > 7'(N)) ? CW'(N) : CW'(vcount_ff);
   always_comb begin
      for (int i = 0; i < N; i++) active[i] = CW'(i) < n;
   end

   logic [N-1:0] row_q;
   assign row_q = rowok_rd_ff ? row_rd_ff : '0;

   apf_pkg::vidx_type w;
   logic found;
   logic [N-1:0] scan_vec;
   logic [CW-1:0] scan_start;
   always_comb begin
      scan_vec = urow_ff & active;
      scan_start = upos_ff;
      case (state_ff)
         S_ROOT: begin
            scan_vec = ~vis_ff & active;
            scan_start = '0;
         end
         S_CNT, S_EMIT: begin
            scan_vec = cut_ff & active;
            scan_start = idx_ff;
         end
         default: ;
      endcase
   end
   apf_scan u_scan (.vec(scan_vec), .start(scan_start), .found(found), .pos(w));

   logic [CW-1:0] tnext, wnext;
   logic push_ok;
   assign tnext = time_ff + 1'b1;
   assign wnext = CW'(w_ff) + 1'b1;
   assign push_ok = !vis_ff[w_ff] && depth_ff < CW'(N);

   // memory ports
   apf_pkg::vidx_type adj_raddr, adj_waddr, disc_waddr, stk_waddr, stk_raddr;
   logic [N-1:0] adj_wdata;
   logic adj_we, disc_we, stk_we;
   apf_pkg::stack_entry_type stk_wdata;
   assign stk_waddr = VW'(depth_ff - 1'b1);
   assign stk_raddr = VW'(depth_ff - 2'd2);
   always_comb begin
      case (state_ff)
         S_IDLE: adj_raddr = VW'(ea - 7'd1);
         S_ADDA: adj_raddr = eb_ff;
         S_ROOT: adj_raddr = w;
         S_EVAL: adj_raddr = w_ff;
         S_POP2: adj_raddr = stk_rd_ff.vertex;
         default: adj_raddr = '0;
      endcase
      adj_we = (state_ff == S_ADDA) || (state_ff == S_ADDB);
      adj_waddr = ea_ff;
      adj_wdata = row_q | (N'(1) << eb_ff);
      if (state_ff == S_ADDB) begin
         adj_waddr = eb_ff;
         adj_wdata = row_q | (N'(1) << ea_ff);
      end
      disc_we = (state_ff == S_ROOT && found) || (state_ff == S_EVAL && push_ok);
      disc_waddr = (state_ff == S_ROOT) ? w : w_ff;
      stk_we = (state_ff == S_EVAL) && push_ok;
      stk_wdata = '{vertex: u_ff, pos: wnext, par: upar_ff, low: ulow_ff, disc: udisc_ff};
   end

   always_ff @(posedge clock) begin
      row_rd_ff <= adj_mem[adj_raddr];
      rowok_rd_ff <= rowok_ff[adj_raddr];
      disc_rd_ff <= disc_mem[w];
      stk_rd_ff <= stack_mem[stk_raddr];
      if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
      if (disc_we) disc_mem[disc_waddr] <= tnext;
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
   end

   logic rsp_fire, emit_last;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign emit_last = (total_ff == '0) || (emitted_ff + 1'b1 == total_ff);

   always_comb begin
      rsp_tvalid = (state_ff == S_EMIT);
      rsp_tlast = emit_last;
      rsp_tuser = (total_ff == '0);
      rsp_tdata = '0;
      if (total_ff != '0) rsp_tdata[6:0] = 7'(w) + 7'd1;
      if (emit_last) rsp_tdata[13:7] = total_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) begin
            if (func == apf_pkg::FUNC_RUN) state_in = S_ROOT;
            else if (func == apf_pkg::FUNC_ADD && edge_ok) state_in = S_ADDA;
         end
         S_ADDA: state_in = S_ADDB;
         S_ADDB: state_in = S_IDLE;
         S_ROOT: state_in = found ? S_LOAD : S_CNT;
         S_LOAD: state_in = S_STEP;
         S_STEP: state_in = found ? S_EVAL : S_POP;
         S_EVAL: state_in = push_ok ? S_LOAD : S_STEP;
         S_POP: state_in = (depth_ff == CW'(1)) ? S_ROOT : S_POP2;
         S_POP2: state_in = S_LOAD;
         S_CNT: if (!found) state_in = S_EMIT;
         S_EMIT: if (rsp_fire && emit_last) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vcount_ff <= 7'(N);
         rowok_ff <= '0;
         vis_ff <= '0;
         cut_ff <= '0;
         depth_ff <= '0;
         time_ff <= '0;
         rootch_ff <= '0;
         idx_ff <= '0;
         total_ff <= '0;
         emitted_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) vcount_ff <= csr_wdata;
         case (state_ff)
            S_IDLE: if (req_tvalid) begin
               if (func == apf_pkg::FUNC_ADD) begin
                  ea_ff <= VW'(ea - 7'd1);
                  eb_ff <= VW'(eb - 7'd1);
               end else if (func == apf_pkg::FUNC_CLEAR) begin
                  rowok_ff <= '0;
               end else if (func == apf_pkg::FUNC_RUN) begin
                  vis_ff <= '0;
                  cut_ff <= '0;
                  time_ff <= '0;
                  idx_ff <= '0;
                  total_ff <= '0;
                  emitted_ff <= '0;
               end
            end
            S_ADDA: rowok_ff[ea_ff] <= 1'b1;
            S_ADDB: rowok_ff[eb_ff] <= 1'b1;
            S_ROOT: if (found) begin
               vis_ff[w] <= 1'b1;
               time_ff <= tnext;
               u_ff <= w;
               upos_ff <= '0;
               upar_ff <= '0;
               ulow_ff <= tnext;
               udisc_ff <= tnext;
               depth_ff <= CW'(1);
               rootch_ff <= '0;
            end
            S_LOAD: urow_ff <= row_q;
            S_STEP: if (found) w_ff <= w;
            S_EVAL: begin
               if (!vis_ff[w_ff]) begin
                  if (upar_ff == '0) rootch_ff <= rootch_ff + 1'b1;
                  if (depth_ff < CW'(N)) begin
                     vis_ff[w_ff] <= 1'b1;
                     time_ff <= tnext;
                     u_ff <= w_ff;
                     upos_ff <= '0;
                     upar_ff <= CW'(u_ff) + 1'b1;
                     ulow_ff <= tnext;
                     udisc_ff <= tnext;
                     depth_ff <= depth_ff + 1'b1;
                  end else begin
                     upos_ff <= wnext;
                  end
               end else begin
                  upos_ff <= wnext;
                  if (wnext != upar_ff && disc_rd_ff < ulow_ff) ulow_ff <= disc_rd_ff;
               end
            end
            S_POP: begin
               depth_ff <= depth_ff - 1'b1;
               if (depth_ff == CW'(1) && rootch_ff > CW'(1)) cut_ff[u_ff] <= 1'b1;
            end
            S_POP2: begin
               u_ff <= stk_rd_ff.vertex;
               upos_ff <= stk_rd_ff.pos;
               upar_ff <= stk_rd_ff.par;
               udisc_ff <= stk_rd_ff.disc;
               ulow_ff <= (ulow_ff < stk_rd_ff.low) ? ulow_ff : stk_rd_ff.low;
               if (stk_rd_ff.par != '0 && ulow_ff >= stk_rd_ff.disc)
                  cut_ff[stk_rd_ff.vertex] <= 1'b1;
            end
            S_CNT: begin
               if (found) begin
                  total_ff <= total_ff + 1'b1;
                  idx_ff <= CW'(w) + 1'b1;
               end else begin
                  idx_ff <= '0;
               end
            end
            S_EMIT: if (rsp_fire) begin
               idx_ff <= CW'(w) + 1'b1;
               emitted_ff <= emitted_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready during run");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CW'(N)) else $error("stack overflow");
   a_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast) else $error("none not last");
`endif
endmodule
